/* hw/rtl/sparse_set_component_store_macros.svh */
// ----------------------------------------------------------------------------
// Sparse set component store assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef SPARSE_SET_COMPONENT_STORE_MACROS_SVH
`define SPARSE_SET_COMPONENT_STORE_MACROS_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge.
`define SSC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sparse set store check failed");
// Same-cycle implication.
`define SSC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sparse set store check failed");
// Next-cycle implication.
`define SSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sparse set store check failed");
`else
`define SSC_ASSERT_ALWAYS(lbl, cond)
`define SSC_ASSERT_IMPL(lbl, ante, cons)
`define SSC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/ssc_pkg.sv */
// ----------------------------------------------------------------------------
// ssc_pkg
// Types, codes and sizes shared by the sparse set component store.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int ENTITY_COUNT  = 256;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int ENT_W         = 8;
  localparam int SLOT_W        = $clog2(ENTITY_COUNT);
  localparam int CNT_W         = $clog2(ENTITY_COUNT + 1);

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_GET    = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_PRESENT = 2'd1,
    STAT_ABSENT  = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]               func;
    logic [ENT_W-1:0]         entity;
    logic [PAYLOAD_WIDTH-1:0] payload;
  } in_item_t;

  typedef struct packed {
    status_t                  status;
    logic [7:0]               slot;
    logic [PAYLOAD_WIDTH-1:0] payload_out;
    logic [CNT_W-1:0]         occupied;
  } out_item_t;

  // Requests from the controller to the three stores.
  typedef struct packed {
    logic                     esm_re;
    logic [ENT_W-1:0]         esm_raddr;
    logic                     esm_we;
    logic [ENT_W-1:0]         esm_waddr;
    logic [SLOT_W-1:0]        esm_wdata;
    logic                     sem_re;
    logic [SLOT_W-1:0]        sem_raddr;
    logic                     sem_we;
    logic [SLOT_W-1:0]        sem_waddr;
    logic [ENT_W-1:0]         sem_wdata;
    logic                     pst_re;
    logic [SLOT_W-1:0]        pst_raddr_idx;
    logic [SLOT_W-1:0]        pst_raddr_last;
    logic                     pst_we;
    logic [SLOT_W-1:0]        pst_waddr;
    logic [PAYLOAD_WIDTH-1:0] pst_wdata;
  } mem_cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0]        esm_rdata;
    logic [ENT_W-1:0]         sem_rdata;
    logic [PAYLOAD_WIDTH-1:0] pst_idx_rdata;
    logic [PAYLOAD_WIDTH-1:0] pst_last_rdata;
  } mem_rsp_t;

endpackage

/* hw/rtl/ssc_ram.sv */
// ----------------------------------------------------------------------------
// ssc_ram
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module ssc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/ssc_ctrl.sv */
// ----------------------------------------------------------------------------
// ssc_ctrl
// Operation sequencer: looks up the entity, reads the slot-side stores,
// then writes back and forms the result.
// ----------------------------------------------------------------------------
`include "sparse_set_component_store_macros.svh"

module ssc_ctrl import ssc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  in_item_t  req,
  input  logic      res_free,
  output logic      done,
  output out_item_t result,
  output mem_cmd_t  cmd,
  input  mem_rsp_t  mem_rsp
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                   state;
  state_t                   state_next;
  logic [1:0]               func_r;
  logic [ENT_W-1:0]         ent_r;
  logic [PAYLOAD_WIDTH-1:0] word_r;
  logic                     present_r;
  logic [SLOT_W-1:0]        idx_r;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [ENTITY_COUNT-1:0]  mapped;
  logic                     fwd_vld;
  logic [ENT_W-1:0]         fwd_addr;
  logic [SLOT_W-1:0]        fwd_data;

  logic                     accept;
  logic                     finish;
  logic [SLOT_W-1:0]        slot_raw;
  logic                     look_present;
  logic [SLOT_W-1:0]        look_idx;
  logic                     set_map;
  logic                     clr_map;
  logic                     wr_ins;
  logic                     wr_rem;

  assign finish    = (state == S_DONE) && res_free;
  assign req_ready = (state == S_IDLE) || finish;
  assign accept    = req_valid && req_ready;
  assign done      = finish;

  // The entity map write of a finishing operation lands on the same edge as
  // the next lookup read, so that read is patched from the forward register.
  assign slot_raw     = (fwd_vld && (fwd_addr == ent_r)) ? fwd_data : mem_rsp.esm_rdata;
  assign look_present = mapped[ent_r];
  assign look_idx     = look_present ? slot_raw : '0;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_LOOK;
      end
      S_LOOK: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (finish) state_next = accept ? S_LOOK : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    result             = '0;
    result.status      = STAT_OK;
    count_next         = count;
    set_map            = 1'b0;
    clr_map            = 1'b0;
    wr_ins             = 1'b0;
    wr_rem             = 1'b0;
    unique case (func_r)
      FUNC_INSERT: begin
        if (present_r) begin
          result.status      = STAT_PRESENT;
          result.slot        = idx_r;
          result.payload_out = mem_rsp.pst_idx_rdata;
        end else if (count == CNT_W'(ENTITY_COUNT)) begin
          result.status = STAT_PRESENT;
        end else begin
          result.slot        = count[SLOT_W-1:0];
          result.payload_out = word_r;
          count_next         = count + 1'b1;
          set_map            = 1'b1;
          wr_ins             = 1'b1;
        end
      end
      FUNC_REMOVE: begin
        if (!present_r) begin
          result.status = STAT_ABSENT;
        end else begin
          result.slot        = idx_r;
          result.payload_out = mem_rsp.pst_idx_rdata;
          count_next         = count - 1'b1;
          clr_map            = 1'b1;
          wr_rem             = 1'b1;
        end
      end
      default: begin
        if (!present_r) begin
          result.status = STAT_ABSENT;
        end else begin
          result.slot        = idx_r;
          result.payload_out = mem_rsp.pst_idx_rdata;
        end
      end
    endcase
    result.occupied = count_next;
  end

  always_comb begin
    cmd                = '0;
    cmd.esm_re         = accept;
    cmd.esm_raddr      = req.entity;
    cmd.sem_re         = (state == S_LOOK);
    cmd.sem_raddr      = SLOT_W'(count - 1'b1);
    cmd.pst_re         = (state == S_LOOK);
    cmd.pst_raddr_idx  = look_idx;
    cmd.pst_raddr_last = SLOT_W'(count - 1'b1);
    if (finish && wr_ins) begin
      cmd.esm_we    = 1'b1;
      cmd.esm_waddr = ent_r;
      cmd.esm_wdata = count[SLOT_W-1:0];
      cmd.sem_we    = 1'b1;
      cmd.sem_waddr = count[SLOT_W-1:0];
      cmd.sem_wdata = ent_r;
      cmd.pst_we    = 1'b1;
      cmd.pst_waddr = count[SLOT_W-1:0];
      cmd.pst_wdata = word_r;
    end else if (finish && wr_rem) begin
      // Swap the last slot into the hole left by the removed entity.
      cmd.esm_we    = 1'b1;
      cmd.esm_waddr = mem_rsp.sem_rdata;
      cmd.esm_wdata = idx_r;
      cmd.sem_we    = 1'b1;
      cmd.sem_waddr = idx_r;
      cmd.sem_wdata = mem_rsp.sem_rdata;
      cmd.pst_we    = 1'b1;
      cmd.pst_waddr = idx_r;
      cmd.pst_wdata = mem_rsp.pst_last_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      mapped  <= '0;
      fwd_vld <= 1'b0;
    end else begin
      state   <= state_next;
      fwd_vld <= cmd.esm_we;
      if (finish) begin
        count <= count_next;
        if (set_map) mapped[ent_r] <= 1'b1;
        if (clr_map) mapped[ent_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= cmd.esm_waddr;
    fwd_data <= cmd.esm_wdata;
    if (accept) begin
      func_r <= req.func;
      ent_r  <= req.entity;
      word_r <= req.payload;
    end
    if (state == S_LOOK) begin
      present_r <= look_present;
      idx_r     <= look_idx;
    end
  end

  `SSC_ASSERT_ALWAYS(a_count_matches_map, $countones(mapped) == 32'(count))
  `SSC_ASSERT_IMPL(a_slot_below_count, (state == S_LOOK) && look_present, {1'b0, slot_raw} < count)
  `SSC_ASSERT_NEXT(a_remove_unmaps, finish && clr_map, !mapped[$past(ent_r)])
  `SSC_ASSERT_NEXT(a_insert_counts, finish && set_map, count == $past(count) + 1'b1)

endmodule

/* hw/rtl/sparse_set_component_store.sv */
// The result is registered after the entity map read and the dependent read
// of the payload store; a new operation is taken only while idle or as the
// last one finishes, and none finishes while the held response is not taken.
// Reset: the mapped bits, the slot count and the handshake state clear in the
// reset cycle; no clearing pass, operations are taken right after reset.
// ----------------------------------------------------------------------------
// sparse_set_component_store
// Sparse set holding one payload word per entity in packed slots, with
// insert, swap-remove and get, and a registered result stage.
// ----------------------------------------------------------------------------
module sparse_set_component_store import ssc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  in_item_t  req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output out_item_t rsp
);

  mem_cmd_t  cmd;
  mem_rsp_t  mem_rsp;
  out_item_t result;
  logic      done;
  logic      res_free;

  assign res_free = !rsp_valid || rsp_ready;

  ssc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_free  (res_free),
    .done      (done),
    .result    (result),
    .cmd       (cmd),
    .mem_rsp   (mem_rsp)
  );

  // Entity to slot map.
  ssc_ram #(.WIDTH(SLOT_W), .DEPTH(ENTITY_COUNT)) u_esm (
    .clk   (clk),
    .we    (cmd.esm_we),
    .waddr (cmd.esm_waddr),
    .wdata (cmd.esm_wdata),
    .re    (cmd.esm_re),
    .raddr (cmd.esm_raddr),
    .rdata (mem_rsp.esm_rdata)
  );

  // Slot to entity map.
  ssc_ram #(.WIDTH(ENT_W), .DEPTH(ENTITY_COUNT)) u_sem (
    .clk   (clk),
    .we    (cmd.sem_we),
    .waddr (cmd.sem_waddr),
    .wdata (cmd.sem_wdata),
    .re    (cmd.sem_re),
    .raddr (cmd.sem_raddr),
    .rdata (mem_rsp.sem_rdata)
  );

  // The payload store is kept in two identical copies so that the entity's
  // slot and the last slot can be read in the same cycle.
  ssc_ram #(.WIDTH(PAYLOAD_WIDTH), .DEPTH(ENTITY_COUNT)) u_pst_idx (
    .clk   (clk),
    .we    (cmd.pst_we),
    .waddr (cmd.pst_waddr),
    .wdata (cmd.pst_wdata),
    .re    (cmd.pst_re),
    .raddr (cmd.pst_raddr_idx),
    .rdata (mem_rsp.pst_idx_rdata)
  );

  ssc_ram #(.WIDTH(PAYLOAD_WIDTH), .DEPTH(ENTITY_COUNT)) u_pst_last (
    .clk   (clk),
    .we    (cmd.pst_we),
    .waddr (cmd.pst_waddr),
    .wdata (cmd.pst_wdata),
    .re    (cmd.pst_re),
    .raddr (cmd.pst_raddr_last),
    .rdata (mem_rsp.pst_last_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp <= result;
    end
  end

endmodule
